@@ src/swqt_pkg.sv @@
// Shared types and constants for the semaphore wait queue table.
// Depends on nothing; every other file but swqt_ram imports it.
`default_nettype none

package swqt_pkg;

   // Fixed field widths of the request and response words
   localparam int FUNC_W = 2;
   localparam int SKEY_W = 32;
   localparam int PID_W  = 5;
   localparam int STAT_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BLOCK  = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_PEEK   = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_BUSY = 2'd1,
      ST_FULL = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_ALLOC,
      S_APPEND,
      S_GOT_PSLOT,
      S_RD_HT,
      S_TAKE_HT,
      S_WALK,
      S_STEP,
      S_REMOVE,
      S_REPLY
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       scan_run;
      logic       take_hit;
      logic       take_free;
      logic       alloc;
      logic       append;
      logic       take_pslot;
      logic       rd_ht;
      logic       take_ht;
      logic       step;
      logic       remove;
      logic       res_set;
      status_type res_status;
      logic       res_found;
      logic       push;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      func_type func;
      logic     pid_ok;
      logic     pid_blocked;
      logic     key_hit;
      logic     scan_last;
      logic     free_any;
      logic     slot_live;
      logic     cur_is_pid;
      logic     cur_is_tail;
      logic     cur_blocked;
      logic     rsp_free;
   } sts_type;

endpackage

`default_nettype wire

@@ src/swqt_if.sv @@
// Handshake channels of the semaphore wait queue table: request and response.
// Depends on swqt_pkg for the field widths.
`default_nettype none

interface swqt_req_if;
   import swqt_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [SKEY_W-1:0] sem_key;
   logic [PID_W-1:0]  proc_id;
   modport source (output valid, func, sem_key, proc_id, input ready);
   modport sink   (input valid, func, sem_key, proc_id, output ready);
endinterface

interface swqt_rsp_if;
   import swqt_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              found;
   logic [PID_W-1:0]  out_proc;
   modport source (output valid, status, found, out_proc, input ready);
   modport sink   (input valid, status, found, out_proc, output ready);
endinterface

`default_nettype wire

@@ src/semaphore_wait_queue_table.sv @@
// Top level of the semaphore wait queue table: controller plus datapath.
// Depends on swqt_pkg, swqt_if, swqt_ctrl, swqt_dp (and swqt_ram below it).
//
//   channel | dir | word fields
//   req_ch  | in  | func, sem_key, proc_id
//   rsp_ch  | out | status, found, out_proc
//
// One word is worked at a time. Block, unblock-head and peek scan the key
// memory one descriptor a cycle. Unblock-given reads the process's
// descriptor, then walks the link memory one link per WALK and STEP state
// pair. A response register lets the next word enter while a response
// waits. Reset is synchronous, clears all valid bits at once and needs no
// clearing pass.
`default_nettype none

module semaphore_wait_queue_table import swqt_pkg::*; #(
   parameter int MAX_PROCS = 32,
   parameter int KEY_WIDTH = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   swqt_req_if.sink    req_ch,
   swqt_rsp_if.source  rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   swqt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .sts(sts), .cmd(cmd)
   );

   swqt_dp #(.MAX_PROCS(MAX_PROCS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_ch.func), .req_sem_key(req_ch.sem_key), .req_proc_id(req_ch.proc_id),
      .rsp_ready(rsp_ch.ready), .rsp_valid(rsp_ch.valid), .rsp_status(rsp_ch.status),
      .rsp_found(rsp_ch.found), .rsp_out_proc(rsp_ch.out_proc)
   );

   // A removed process must still be marked blocked
   a_remove_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |-> sts.cur_blocked)
      else $error("removing a process that is not blocked");

   // Allocation only takes a free descriptor
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !sts.slot_live)
      else $error("allocating a live descriptor");

   // No second word enters right after one is taken
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready held after accepting a word");

   // A pushed result shows up on the response channel
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_ch.valid)
      else $error("pushed response not presented");

endmodule

`default_nettype wire

@@ src/swqt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module swqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/swqt_ctrl.sv @@
// Controller state machine of the semaphore wait queue table.
// Depends on swqt_pkg; drives the datapath through cmd_type.
`default_nettype none

module swqt_ctrl import swqt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one word through lookup, walk and writeback
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.scan_init = 1'b1;
            case (sts.func)
               FUNC_BLOCK: begin
                  if (!sts.pid_ok) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_MISS;
                     state_in       = S_REPLY;
                  end else if (sts.pid_blocked) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_BUSY;
                     state_in       = S_REPLY;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               FUNC_REMOVE: begin
                  if (!sts.pid_ok || !sts.pid_blocked) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_MISS;
                     state_in       = S_REPLY;
                  end else begin
                     state_in = S_GOT_PSLOT;
                  end
               end
               default: begin
                  state_in = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.key_hit) begin
               cmd.take_hit = 1'b1;
               state_in     = (sts.func == FUNC_BLOCK) ? S_APPEND : S_WALK;
            end else if (sts.scan_last) begin
               cmd.res_set = 1'b1;
               if (sts.func == FUNC_BLOCK && sts.free_any) begin
                  cmd.res_set   = 1'b0;
                  cmd.take_free = 1'b1;
                  state_in      = S_ALLOC;
               end else if (sts.func == FUNC_BLOCK) begin
                  cmd.res_status = ST_FULL;
                  state_in       = S_REPLY;
               end else begin
                  cmd.res_status = ST_MISS;
                  state_in       = S_REPLY;
               end
            end
         end
         S_ALLOC: begin
            cmd.alloc      = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            state_in       = S_REPLY;
         end
         S_APPEND: begin
            cmd.append     = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            state_in       = S_REPLY;
         end
         S_GOT_PSLOT: begin
            cmd.take_pslot = 1'b1;
            state_in       = S_RD_HT;
         end
         S_RD_HT: begin
            cmd.rd_ht = 1'b1;
            if (!sts.slot_live) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_REPLY;
            end else begin
               state_in = S_TAKE_HT;
            end
         end
         S_TAKE_HT: begin
            cmd.take_ht = 1'b1;
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (sts.func != FUNC_REMOVE || sts.cur_is_pid) begin
               if (sts.func == FUNC_PEEK) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_OK;
                  cmd.res_found  = 1'b1;
                  state_in       = S_REPLY;
               end else begin
                  state_in = S_REMOVE;
               end
            end else if (sts.cur_is_tail) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_REPLY;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_WALK;
         end
         S_REMOVE: begin
            cmd.remove     = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_found  = 1'b1;
            state_in       = S_REPLY;
         end
         S_REPLY: begin
            if (sts.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/swqt_dp.sv @@
// Datapath of the semaphore wait queue table: descriptor and link memories,
// key scan, chain walk and response register. Depends on swqt_pkg and swqt_ram.
`default_nettype none

module swqt_dp import swqt_pkg::*; #(
   parameter int MAX_PROCS = 32,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [SKEY_W-1:0] req_sem_key,
   input  wire logic [PID_W-1:0]  req_proc_id,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_found,
   output logic [PID_W-1:0]       rsp_out_proc
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);
   localparam logic [CW-1:0] SCAN_END = CW'(MAX_PROCS);

   // Latched request word
   func_type            func_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [PID_W-1:0]    pid_ff;
   logic [IW-1:0]       pid_idx;

   // Scan pipeline
   logic [CW-1:0] scan_ff;
   logic [IW-1:0] scan_idx;
   logic          chk_vld_ff;
   logic [IW-1:0] chk_idx_ff;
   logic          free_vld_ff;
   logic [IW-1:0] free_idx_ff;
   logic          chk_free;

   // Walk registers
   logic [IW-1:0] slot_ff, cur_ff, tail_ff, prev_ff;
   logic          prev_vld_ff;

   // Valid bits
   logic [MAX_PROCS-1:0] slot_valid_ff;
   logic [MAX_PROCS-1:0] proc_blocked_ff;

   // Result and output register
   status_type        res_status_ff;
   logic              res_found_ff;
   logic [PID_W-1:0]  res_proc_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_found_ff;
   logic [PID_W-1:0]  rsp_proc_ff;

   // Memory ports
   logic [KEY_WIDTH-1:0] key_rd;
   logic [IW-1:0]        head_rd, tail_rd, pslot_rd, next_rd;
   logic [IW-1:0]        ht_rd_addr;
   logic                 head_we, tail_we, next_we, pslot_we;
   logic [IW-1:0]        head_wd, tail_wd, next_wd, next_wa;

   assign pid_idx  = IW'(pid_ff);
   assign scan_idx = scan_ff[IW-1:0];
   assign chk_free = chk_vld_ff && !slot_valid_ff[chk_idx_ff];

   // Status to controller
   always_comb begin
      sts.func        = func_ff;
      sts.pid_ok      = int'(pid_ff) < MAX_PROCS;
      sts.pid_blocked = proc_blocked_ff[pid_idx];
      sts.key_hit     = chk_vld_ff && slot_valid_ff[chk_idx_ff] && (key_rd == key_ff);
      sts.scan_last   = chk_vld_ff && (chk_idx_ff == LAST_IDX);
      sts.free_any    = free_vld_ff || chk_free;
      sts.slot_live   = slot_valid_ff[slot_ff];
      sts.cur_is_pid  = cur_ff == pid_idx;
      sts.cur_is_tail = cur_ff == tail_ff;
      sts.cur_blocked = proc_blocked_ff[cur_ff];
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Memory write and read selection
   always_comb begin
      ht_rd_addr = cmd.rd_ht ? slot_ff : scan_idx;
      head_we    = cmd.alloc || (cmd.remove && !prev_vld_ff && (cur_ff != tail_ff));
      head_wd    = cmd.alloc ? pid_idx : next_rd;
      tail_we    = cmd.alloc || cmd.append || (cmd.remove && prev_vld_ff && (cur_ff == tail_ff));
      tail_wd    = (cmd.alloc || cmd.append) ? pid_idx : prev_ff;
      pslot_we   = cmd.alloc || cmd.append;
      next_we    = cmd.append || (cmd.remove && prev_vld_ff);
      next_wa    = cmd.append ? tail_ff : prev_ff;
      next_wd    = cmd.append ? pid_idx : next_rd;
   end

   swqt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_PROCS)) u_key_ram (
      .clock(clock), .wr_en(cmd.alloc), .wr_addr(slot_ff), .wr_data(key_ff),
      .rd_addr(scan_idx), .rd_data(key_rd)
   );

   swqt_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(slot_ff), .wr_data(head_wd),
      .rd_addr(ht_rd_addr), .rd_data(head_rd)
   );

   swqt_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_tail_ram (
      .clock(clock), .wr_en(tail_we), .wr_addr(slot_ff), .wr_data(tail_wd),
      .rd_addr(ht_rd_addr), .rd_data(tail_rd)
   );

   swqt_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_pslot_ram (
      .clock(clock), .wr_en(pslot_we), .wr_addr(pid_idx), .wr_data(slot_ff),
      .rd_addr(pid_idx), .rd_data(pslot_rd)
   );

   swqt_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(cur_ff), .rd_data(next_rd)
   );

   // Latch request word, advance scan and walk registers, load result and output registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         key_ff  <= KEY_WIDTH'(req_sem_key);
         pid_ff  <= req_proc_id;
      end
      if (cmd.scan_run) begin
         chk_idx_ff <= scan_idx;
         if (chk_free && !free_vld_ff) begin
            free_idx_ff <= chk_idx_ff;
         end
      end
      if (cmd.take_hit) begin
         slot_ff <= chk_idx_ff;
      end else if (cmd.take_free) begin
         slot_ff <= free_vld_ff ? free_idx_ff : chk_idx_ff;
      end else if (cmd.take_pslot) begin
         slot_ff <= pslot_rd;
      end
      if (cmd.take_hit || cmd.take_ht) begin
         cur_ff  <= head_rd;
         tail_ff <= tail_rd;
      end else if (cmd.step) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_rd;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found;
         res_proc_ff   <= cmd.res_found ? PID_W'(cur_ff) : '0;
      end
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_proc_ff   <= res_proc_ff;
      end
   end

   // Control flags, valid bits and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff         <= '0;
         chk_vld_ff      <= 1'b0;
         free_vld_ff     <= 1'b0;
         prev_vld_ff     <= 1'b0;
         slot_valid_ff   <= '0;
         proc_blocked_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.scan_init) begin
            scan_ff     <= '0;
            chk_vld_ff  <= 1'b0;
            free_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            chk_vld_ff <= scan_ff != SCAN_END;
            if (scan_ff != SCAN_END) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (chk_free) begin
               free_vld_ff <= 1'b1;
            end
         end
         if (cmd.take_hit || cmd.take_ht) begin
            prev_vld_ff <= 1'b0;
         end else if (cmd.step) begin
            prev_vld_ff <= 1'b1;
         end
         if (cmd.alloc) begin
            slot_valid_ff[slot_ff] <= 1'b1;
         end
         if (cmd.alloc || cmd.append) begin
            proc_blocked_ff[pid_idx] <= 1'b1;
         end
         if (cmd.remove) begin
            proc_blocked_ff[cur_ff] <= 1'b0;
            if (!prev_vld_ff && (cur_ff == tail_ff)) begin
               slot_valid_ff[slot_ff] <= 1'b0;
            end
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_out_proc = rsp_proc_ff;

endmodule

`default_nettype wire
